// File: rtl/fccw_pkg.sv
package fccw_pkg;

    localparam int TABLE_BYTES  = 4608;
    localparam int SECTOR_BYTES = 512;
    localparam int MAX_CLUSTERS = 64;

    localparam int ADDR_W  = $clog2(TABLE_BYTES);
    localparam int IDX_W   = 13;
    localparam int CLUS_W  = 12;
    localparam int SECT_W  = 13;
    localparam int FSIZE_W = 21;
    localparam int CNT_W   = 10;
    localparam int NUM_W   = $clog2(MAX_CLUSTERS + 1);

    localparam logic [SECT_W-1:0] SECTOR_OFFSET = SECT_W'(33 - 2);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_WALK  = 1'b1;

    localparam logic [1:0] ST_CONT = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;
    localparam logic [1:0] ST_CAP  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic wr;      // store the accepted table byte
        logic start;   // load a new walk
        logic rd_hi;   // address the upper byte of the entry
        logic cap_lo;  // hold the lower byte
        logic emit;    // try to load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_ok;  // first cluster is neither free nor an end marker
        logic emitted;   // result register was loaded this cycle
        logic last;      // the loaded result closes the walk
    } t_stat;

    function automatic logic is_end(input logic [CLUS_W-1:0] v);
        return &v[CLUS_W-1:3];
    endfunction

endpackage

// File: rtl/fccw_ctrl.sv
module fccw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_operation,
    input  fccw_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output fccw_pkg::t_cmd  o_cmd
);
    import fccw_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_WALK && i_stat.start_ok) begin
                    n_state = S_RD_LO;
                end
            end
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.emitted) begin
                    n_state = i_stat.last ? S_IDLE : S_RD_LO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.wr    = accept && i_operation == OP_WRITE;
                o_cmd.start = accept && i_operation == OP_WALK;
            end
            S_RD_LO: o_cmd.rd_hi = 1'b0;
            S_RD_HI: begin
                o_cmd.rd_hi  = 1'b1;
                o_cmd.cap_lo = 1'b1;
            end
            S_EMIT: begin
                // keep addressing the upper byte so the read data holds while stalled
                o_cmd.rd_hi = 1'b1;
                o_cmd.emit  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/fccw_dp.sv
module fccw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fccw_pkg::t_cmd                i_cmd,
    input  logic [fccw_pkg::IDX_W-1:0]    i_table_index,
    input  logic [7:0]                    i_table_byte,
    input  logic [fccw_pkg::CLUS_W-1:0]   i_start_cluster,
    input  logic [fccw_pkg::FSIZE_W-1:0]  i_file_bytes,
    input  logic                          i_out_ready,
    output fccw_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output logic [fccw_pkg::CLUS_W-1:0]   o_cluster,
    output logic [fccw_pkg::SECT_W-1:0]   o_sector,
    output logic [fccw_pkg::CNT_W-1:0]    o_byte_count,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import fccw_pkg::*;

    logic [7:0] mem [TABLE_BYTES];

    logic [CLUS_W-1:0]  r_cur;
    logic [FSIZE_W-1:0] r_fsize;
    logic [FSIZE_W-1:0] r_done;
    logic [NUM_W-1:0]   r_num;
    logic [7:0]         r_rdata;
    logic               r_rd_ok;
    logic [7:0]         r_lo;
    logic               r_valid;

    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   rd_addr;
    logic [7:0]         hi_byte;
    logic [15:0]        half;
    logic [CLUS_W-1:0]  nxt;
    logic [FSIZE_W-1:0] left;
    logic [FSIZE_W-1:0] cnt;
    logic [1:0]         st;
    logic               lst;
    logic               out_free;
    logic               do_emit;

    assign pos     = {1'b0, r_cur} + {2'b00, r_cur[CLUS_W-1:1]};
    assign rd_addr = i_cmd.rd_hi ? pos + IDX_W'(1) : pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_table_index < IDX_W'(TABLE_BYTES)) begin
            mem[i_table_index[ADDR_W-1:0]] <= i_table_byte;
        end
        r_rd_ok <= rd_addr < IDX_W'(TABLE_BYTES);
        if (rd_addr < IDX_W'(TABLE_BYTES)) begin
            r_rdata <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    assign hi_byte = r_rd_ok ? r_rdata : 8'h00;
    assign half    = {hi_byte, r_lo};
    assign nxt     = r_cur[0] ? half[15:4] : half[11:0];
    assign left    = (r_fsize > r_done) ? r_fsize - r_done : '0;
    assign cnt     = (left < FSIZE_W'(SECTOR_BYTES)) ? left : FSIZE_W'(SECTOR_BYTES);

    always_comb begin
        st  = ST_CONT;
        lst = 1'b0;
        if (is_end(nxt)) begin
            st  = ST_END;
            lst = 1'b1;
        end else if (nxt == '0) begin
            st  = ST_FREE;
            lst = 1'b1;
        end else if (r_num == NUM_W'(MAX_CLUSTERS - 1)) begin
            st  = ST_CAP;
            lst = 1'b1;
        end
    end

    assign out_free = !r_valid || i_out_ready;
    assign do_emit  = i_cmd.emit && out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_lo <= r_rd_ok ? r_rdata : 8'h00;
        end
        if (i_cmd.start) begin
            r_cur   <= i_start_cluster;
            r_fsize <= i_file_bytes;
        end else if (do_emit) begin
            r_cur <= nxt;
        end
        if (do_emit) begin
            o_cluster    <= r_cur;
            o_sector     <= {1'b0, r_cur} + SECTOR_OFFSET;
            o_byte_count <= cnt[CNT_W-1:0];
            o_status     <= st;
            o_last       <= lst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
            r_num   <= '0;
        end else begin
            if (do_emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.start) begin
                r_done <= '0;
                r_num  <= '0;
            end else if (do_emit) begin
                r_done <= r_done + cnt;
                r_num  <= r_num + NUM_W'(1);
            end
        end
    end

    assign o_stat.start_ok = !(i_start_cluster == '0) && !is_end(i_start_cluster);
    assign o_stat.emitted  = do_emit;
    assign o_stat.last     = lst;
    assign o_out_valid     = r_valid;

endmodule

// File: rtl/fat12_cluster_chain_walker_top.sv
// FAT12 cluster chain walker. Load the allocation table with write transfers
// (operation 0, one byte at table_index; indexes at or past 4608 are dropped),
// then issue a walk transfer (operation 1) with a first cluster and a file
// length. The block follows the packed 12-bit chain and returns one result
// per visited cluster: the cluster, its data sector (cluster + 31), the file
// bytes in that sector (up to 512, zero once the file is used up), a status
// (0 continues, 1 next is an end marker 0xFF8..0xFFF, 2 next is free, 3 the
// 64-result cap) and last on the closing result. A walk that starts on a
// free cluster or an end marker returns nothing. Table bytes that were never
// written read as anything. Each cluster takes two reads of the table
// memory, low byte then high byte, and a result step that waits while the
// output stalls. The result register lets the next cluster's reads run
// while a result waits to be taken. New input is taken only between walks.
// There is no clearing pass after reset.
module fat12_cluster_chain_walker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [fccw_pkg::IDX_W-1:0]    i_table_index,
    input  logic [7:0]                    i_table_byte,
    input  logic [fccw_pkg::CLUS_W-1:0]   i_start_cluster,
    input  logic [fccw_pkg::FSIZE_W-1:0]  i_file_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fccw_pkg::CLUS_W-1:0]   o_cluster,
    output logic [fccw_pkg::SECT_W-1:0]   o_sector,
    output logic [fccw_pkg::CNT_W-1:0]    o_byte_count,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import fccw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequence the walk: idle, low byte read, high byte read, result
    fccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // table memory, chain registers and the result register
    fccw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_table_index   (i_table_index),
        .i_table_byte    (i_table_byte),
        .i_start_cluster (i_start_cluster),
        .i_file_bytes    (i_file_bytes),
        .i_out_ready     (i_out_ready),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_cluster       (o_cluster),
        .o_sector        (o_sector),
        .o_byte_count    (o_byte_count),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

// File: rtl/fccw_checker.sv
module fccw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [fccw_pkg::CLUS_W-1:0]   o_cluster,
    input logic [fccw_pkg::SECT_W-1:0]   o_sector,
    input logic [fccw_pkg::CNT_W-1:0]    o_byte_count,
    input logic [1:0]                    o_status,
    input logic                          o_last
);
    import fccw_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cluster)
            && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sector == ({1'b0, o_cluster} + SECTOR_OFFSET))
        else $error("sector does not match cluster");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_count <= CNT_W'(SECTOR_BYTES))
        else $error("byte count above sector size");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_status != ST_CONT)))
        else $error("last and status disagree");

    // while a walk is unfinished no new input is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready in the middle of a walk");

endmodule

bind fat12_cluster_chain_walker_top fccw_checker u_fccw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cluster    (o_cluster),
    .o_sector     (o_sector),
    .o_byte_count (o_byte_count),
    .o_status     (o_status),
    .o_last       (o_last)
);
